>>> rtl/core/pte_pkg.sv
// ----------------------------------------------------------------------------
// Pheromone table engine package
// Shared widths, register reset values, operation and register codes, the
// sequencer state type and the saturating add used by the table logic.
// ----------------------------------------------------------------------------
`default_nettype none

package pte_pkg;

    // Field and register widths.
    localparam int LEVEL_W    = 32;
    localparam int RATE_W     = 16;
    localparam int FRAC_W     = 16;
    localparam int OP_W       = 3;
    localparam int IDX_W      = 7;
    localparam int NCOUNT_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Register values after reset.
    localparam logic [NCOUNT_W-1:0] NODE_COUNT_RST = 8'd0;
    localparam logic [RATE_W-1:0]   EVAP_RATE_RST  = 16'd26214;
    localparam logic [LEVEL_W-1:0]  INIT_LEVEL_RST = 32'd6553600;
    localparam logic [LEVEL_W-1:0]  FLOOR_RST      = 32'd66;

    // Operation codes carried by an item.
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 3'd0,
        OP_ADD   = 3'd1,
        OP_EVAP  = 3'd2,
        OP_READ  = 3'd3,
        OP_MAX   = 3'd4
    } t_op;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_COUNT  = 2'd0,
        CFG_EVAP_RATE   = 2'd1,
        CFG_INIT_LEVEL  = 2'd2,
        CFG_FLOOR_LEVEL = 2'd3
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ADD1,
        ST_ADD2,
        ST_READ,
        ST_SWEEP,
        ST_DONE
    } t_state;

    // Add two levels and saturate at the largest level.
    function automatic logic [LEVEL_W-1:0] sat_add(input logic [LEVEL_W-1:0] a,
                                                   input logic [LEVEL_W-1:0] b);
        logic [LEVEL_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[LEVEL_W] ? {LEVEL_W{1'b1}} : sum[LEVEL_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/pte_ram.sv
// ----------------------------------------------------------------------------
// Pheromone table memory
// Simple dual-port synchronous memory: one write port and one read port with
// registered read data (old data on a same-cycle write).
// ----------------------------------------------------------------------------
`default_nettype none

module pte_ram #(
    parameter int ADDR_W = 14,
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/pheromone_table_engine.sv
// ----------------------------------------------------------------------------
// Pheromone table engine
// Square table of UQ16.16 pheromone levels with clear, symmetric deposit,
// evaporation with a floor, single-entry read and maximum search.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on i_valid/o_ready and each gives one result on o_valid/i_ready.
// Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data while idle;
// the user must keep to this, as the block itself does not enforce it. The
// table sits in one synchronous memory, addressed as {row, column}, and the
// block works on one item at a time. Unknown codes, out-of-range indexes and
// sweeps with no active nodes go straight to the result. A read passes through
// the memory read, then the result register. An add makes two
// read-modify-write passes through the memory port. Evaporate and maximum
// sweep N*N entries, where N is the active node count, one entry per cycle;
// evaporate runs them through a read, multiply, write pipeline, and maximum
// compares each entry read and writes nothing. Clear writes the whole memory.
// A new item is taken in the cycle after the previous result is registered, so
// a result may still wait at the output while the next item is accepted.
// If the receiver stalls with a result held, a finished result waits inside
// until the output register frees up, and no further item is accepted.
// After reset the block sweeps the whole memory with the reset initial level,
// with o_ready low; configuration writes are taken during that sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module pheromone_table_engine #(
    parameter int MAX_NODES = 128
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration port
    input  logic                             i_cfg_we,
    input  logic [pte_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pte_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Input item channel
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [pte_pkg::OP_W-1:0]         i_operation,
    input  logic [pte_pkg::IDX_W-1:0]        i_origin,
    input  logic [pte_pkg::IDX_W-1:0]        i_destination,
    input  logic [pte_pkg::LEVEL_W-1:0]      i_amount,
    // Result item channel
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [pte_pkg::LEVEL_W-1:0]      o_value,
    output logic [pte_pkg::OP_W-1:0]         o_done_kind
);

    import pte_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int ADDR_W = 2 * NODE_W;
    localparam int PROD_W = LEVEL_W + FRAC_W + 1;

    // Control registers.
    t_state                r_state,        n_state;
    logic [NCOUNT_W-1:0]   r_node_count,   n_node_count;
    logic [RATE_W-1:0]     r_rate,         n_rate;
    logic [LEVEL_W-1:0]    r_init,         n_init;
    logic [LEVEL_W-1:0]    r_floor,        n_floor;
    logic [NODE_W-1:0]     r_x,            n_x;
    logic [NODE_W-1:0]     r_y,            n_y;
    logic                  r_clr_op,       n_clr_op;
    logic                  r_issue,        n_issue;
    logic                  r_p1_vld,       n_p1_vld;
    logic                  r_p2_vld,       n_p2_vld;
    logic                  r_out_valid,    n_out_valid;

    // Payload registers.
    logic [ADDR_W-1:0]     r_p1_addr,      n_p1_addr;
    logic [ADDR_W-1:0]     r_p2_addr,      n_p2_addr;
    logic [LEVEL_W-1:0]    r_prod,         n_prod;
    logic [LEVEL_W-1:0]    r_best,         n_best;
    logic [OP_W-1:0]       r_kind,         n_kind;
    logic [ADDR_W-1:0]     r_addr_a,       n_addr_a;
    logic [ADDR_W-1:0]     r_addr_b,       n_addr_b;
    logic [LEVEL_W-1:0]    r_amount,       n_amount;
    logic [LEVEL_W-1:0]    r_sum,          n_sum;
    logic [LEVEL_W-1:0]    r_res_value,    n_res_value;
    logic [LEVEL_W-1:0]    r_out_value,    n_out_value;
    logic [OP_W-1:0]       r_out_kind,     n_out_kind;

    // Memory port signals.
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [LEVEL_W-1:0]    ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [LEVEL_W-1:0]    r_rd_data;

    // Datapath helpers.
    logic [31:0]           org_ext;
    logic [31:0]           dst_ext;
    logic [NODE_W-1:0]     org_idx;
    logic [NODE_W-1:0]     dst_idx;
    logic                  in_range;
    logic [CNT_W-1:0]      active_n;
    logic [FRAC_W:0]       factor;
    logic [PROD_W-1:0]     product;
    logic [LEVEL_W-1:0]    evap_val;
    logic [LEVEL_W-1:0]    add1_val;
    logic [LEVEL_W-1:0]    add2_base;
    logic [LEVEL_W-1:0]    add2_val;
    logic                  x_last;
    logic                  y_last;
    logic                  load_out;

    // Table memory.
    pte_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (LEVEL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (r_rd_data)
    );

    // Node indexes and range check on the incoming item.
    assign org_ext  = 32'(i_origin);
    assign dst_ext  = 32'(i_destination);
    assign org_idx  = org_ext[NODE_W-1:0];
    assign dst_idx  = dst_ext[NODE_W-1:0];
    assign in_range = (org_ext < 32'(MAX_NODES)) && (dst_ext < 32'(MAX_NODES));

    // Active node count, limited to the table size.
    assign active_n = (32'(r_node_count) > 32'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                          : CNT_W'(r_node_count);

    // Sweep position checks.
    assign x_last = (CNT_W'(r_x) + CNT_W'(1)) == active_n;
    assign y_last = (CNT_W'(r_y) + CNT_W'(1)) == active_n;

    // Evaporation: scale by one minus the rate, then clamp up to the floor.
    assign factor   = (FRAC_W + 1)'(1 << FRAC_W) - (FRAC_W + 1)'(r_rate);
    assign product  = PROD_W'(r_rd_data) * PROD_W'(factor);
    assign evap_val = (r_prod <= r_floor) ? r_floor : r_prod;

    // Deposits; the second one sees the first when both hit the same entry.
    assign add1_val  = sat_add(r_rd_data, r_amount);
    assign add2_base = (r_addr_b == r_addr_a) ? r_sum : r_rd_data;
    assign add2_val  = sat_add(add2_base, r_amount);

    // Sequencer, memory port control and next register values.
    always_comb begin
        n_state      = r_state;
        n_node_count = r_node_count;
        n_rate       = r_rate;
        n_init       = r_init;
        n_floor      = r_floor;
        n_x          = r_x;
        n_y          = r_y;
        n_clr_op     = r_clr_op;
        n_issue      = r_issue;
        n_p1_addr    = r_p1_addr;
        n_best       = r_best;
        n_kind       = r_kind;
        n_addr_a     = r_addr_a;
        n_addr_b     = r_addr_b;
        n_amount     = r_amount;
        n_sum        = r_sum;
        n_res_value  = r_res_value;
        o_ready      = 1'b0;
        load_out     = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = r_p2_addr;
        ram_wdata    = evap_val;
        ram_raddr    = {dst_idx, org_idx};

        // Configuration writes.
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_NODE_COUNT:  n_node_count = i_cfg_data[NCOUNT_W-1:0];
                CFG_EVAP_RATE:   n_rate       = i_cfg_data[RATE_W-1:0];
                CFG_INIT_LEVEL:  n_init       = i_cfg_data[LEVEL_W-1:0];
                CFG_FLOOR_LEVEL: n_floor      = i_cfg_data[LEVEL_W-1:0];
                default:         n_node_count = r_node_count;
            endcase
        end

        // Sweep pipeline: read data stage, then product stage, then write.
        n_p1_vld  = 1'b0;
        n_p2_vld  = r_p1_vld && (r_kind == OP_EVAP);
        n_p2_addr = r_p1_addr;
        n_prod    = product[LEVEL_W+FRAC_W-1:FRAC_W];
        if (r_p1_vld && (r_kind == OP_MAX) && (r_rd_data > r_best)) begin
            n_best = r_rd_data;
        end
        if (r_p2_vld) begin
            ram_we    = 1'b1;
            ram_waddr = r_p2_addr;
            ram_wdata = evap_val;
        end

        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_kind      = i_operation;
                    n_res_value = '0;
                    n_amount    = i_amount;
                    n_addr_a    = {dst_idx, org_idx};
                    n_addr_b    = {org_idx, dst_idx};
                    n_x         = '0;
                    n_y         = '0;
                    n_best      = '0;
                    case (i_operation) inside
                        OP_CLEAR: begin
                            n_state  = ST_CLEAR;
                            n_clr_op = 1'b1;
                        end
                        OP_ADD:  n_state = in_range ? ST_ADD1 : ST_DONE;
                        OP_READ: n_state = in_range ? ST_READ : ST_DONE;
                        OP_EVAP, OP_MAX: begin
                            n_issue = (active_n != '0);
                            n_state = (active_n != '0) ? ST_SWEEP : ST_DONE;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR: begin
                // The pass after reset always fills with the reset level.
                ram_we     = 1'b1;
                ram_waddr  = {r_y, r_x};
                ram_wdata  = r_clr_op ? r_init : INIT_LEVEL_RST;
                {n_y, n_x} = ADDR_W'({r_y, r_x} + 1'b1);
                if (&{r_y, r_x}) begin
                    n_state = r_clr_op ? ST_DONE : ST_IDLE;
                end
            end
            ST_ADD1: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr_a;
                ram_wdata = add1_val;
                n_sum     = add1_val;
                ram_raddr = r_addr_b;
                n_state   = ST_ADD2;
            end
            ST_ADD2: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr_b;
                ram_wdata = add2_val;
                n_state   = ST_DONE;
            end
            ST_READ: begin
                n_res_value = r_rd_data;
                n_state     = ST_DONE;
            end
            ST_SWEEP: begin
                ram_raddr = {r_y, r_x};
                if (r_issue) begin
                    n_p1_vld  = 1'b1;
                    n_p1_addr = {r_y, r_x};
                    if (x_last) begin
                        n_x = '0;
                        if (y_last) begin
                            n_issue = 1'b0;
                        end else begin
                            n_y = r_y + 1'b1;
                        end
                    end else begin
                        n_x = r_x + 1'b1;
                    end
                end
                if (!r_issue && !r_p1_vld && !r_p2_vld) begin
                    n_res_value = (r_kind == OP_MAX) ? r_best : '0;
                    n_state     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_clr_op = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // Output register.
        n_out_value = r_out_value;
        n_out_kind  = r_out_kind;
        n_out_valid = r_out_valid && !i_ready;
        if (load_out) begin
            n_out_valid = 1'b1;
            n_out_value = r_res_value;
            n_out_kind  = r_kind;
        end
    end

    // Control state with reset; reset starts the clearing sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_node_count <= NODE_COUNT_RST;
            r_rate       <= EVAP_RATE_RST;
            r_init       <= INIT_LEVEL_RST;
            r_floor      <= FLOOR_RST;
            r_x          <= '0;
            r_y          <= '0;
            r_clr_op     <= 1'b0;
            r_issue      <= 1'b0;
            r_p1_vld     <= 1'b0;
            r_p2_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_node_count <= n_node_count;
            r_rate       <= n_rate;
            r_init       <= n_init;
            r_floor      <= n_floor;
            r_x          <= n_x;
            r_y          <= n_y;
            r_clr_op     <= n_clr_op;
            r_issue      <= n_issue;
            r_p1_vld     <= n_p1_vld;
            r_p2_vld     <= n_p2_vld;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_p1_addr   <= n_p1_addr;
        r_p2_addr   <= n_p2_addr;
        r_prod      <= n_prod;
        r_best      <= n_best;
        r_kind      <= n_kind;
        r_addr_a    <= n_addr_a;
        r_addr_b    <= n_addr_b;
        r_amount    <= n_amount;
        r_sum       <= n_sum;
        r_res_value <= n_res_value;
        r_out_value <= n_out_value;
        r_out_kind  <= n_out_kind;
    end

    assign o_valid     = r_out_valid;
    assign o_value     = r_out_value;
    assign o_done_kind = r_out_kind;

`ifndef SYNTHESIS
    // An evaporation write never lands below the floor.
    a_evap_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2_vld |-> (ram_wdata >= r_floor))
        else $error("evaporation wrote a level below the floor");

    // The first deposit saturates instead of wrapping.
    a_add_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD1) |-> (ram_wdata >= r_rd_data))
        else $error("deposit wrapped around");

    // Nothing writes the table while the block waits for an item.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !ram_we)
        else $error("table written while idle");

    // A finished result reaches the output register once it is free.
    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && (!r_out_valid || i_ready)) |=> o_valid)
        else $error("finished result not presented");
`endif

endmodule

`default_nettype wire

>>> sim/tb_pheromone_table_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pheromone table engine testbench
// Drives operation items into the engine and checks every result against a
// behavioral copy of the pheromone table. The run covers the state after
// reset, deposits with saturation, evaporation at the rate and floor
// extremes, clears, output back-pressure and many random register settings.
// ----------------------------------------------------------------------------

module tb_pheromone_table_engine;
    import pte_pkg::*;

    localparam int NODES            = 128;
    localparam int DEPTH            = NODES * NODES;
    localparam int CLK_HALF         = 4;
    localparam int RESET_CYCLES     = 3;
    localparam int TIMEOUT_NS       = 20_000_000;
    localparam int SETTLE_CYCLES    = 64;
    localparam int STALL_CYCLES     = 300;
    localparam int RANDOM_PHASES    = 12;
    localparam int ITEMS_PER_PHASE  = 102;
    localparam int SMALL_NODE_LIMIT = 16;
    localparam int FIRST_UNUSED_OP  = int'(OP_MAX) + 1;
    localparam int LAST_OP_CODE     = (1 << OP_W) - 1;
    localparam logic [LEVEL_W-1:0] LEVEL_TOP = {LEVEL_W{1'b1}};
    localparam logic [RATE_W-1:0]  RATE_TOP  = {RATE_W{1'b1}};

    typedef struct packed {
        logic [LEVEL_W-1:0] value;
        logic [OP_W-1:0]    kind;
    } t_outcome;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic [OP_W-1:0]       i_operation;
    logic [IDX_W-1:0]      i_origin;
    logic [IDX_W-1:0]      i_destination;
    logic [LEVEL_W-1:0]    i_amount;
    logic                  o_valid;
    logic                  i_ready;
    logic [LEVEL_W-1:0]    o_value;
    logic [OP_W-1:0]       o_done_kind;

    // Behavioral copy of the table and its registers.
    logic [LEVEL_W-1:0]  level_table [DEPTH];
    logic [NCOUNT_W-1:0] node_count_reg;
    logic [RATE_W-1:0]   rate_reg;
    logic [LEVEL_W-1:0]  init_reg;
    logic [LEVEL_W-1:0]  floor_reg;
    t_outcome            awaited_outcomes [$];

    int  mismatch_count   = 0;
    int  results_checked  = 0;
    int  settings_applied = 0;
    int  op_tally [8];
    int  rx_hold_left     = 0;
    int  rx_gap_left      = 0;
    bit  tx_idle_on       = 1'b1;
    bit  rx_idle_on       = 1'b1;

    pheromone_table_engine #(
        .MAX_NODES(NODES)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_operation  (i_operation),
        .i_origin     (i_origin),
        .i_destination(i_destination),
        .i_amount     (i_amount),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_value      (o_value),
        .o_done_kind  (o_done_kind)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Safety net against a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("** pheromone_table_engine: FAILED **");
        $finish;
    end

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Add a deposit to a level and saturate at the top level.
    function automatic logic [LEVEL_W-1:0] deposit_level(input logic [LEVEL_W-1:0] level,
                                                         input logic [LEVEL_W-1:0] amt);
        logic [LEVEL_W:0] sum;
        sum = {1'b0, level} + {1'b0, amt};
        return sum[LEVEL_W] ? LEVEL_TOP : sum[LEVEL_W-1:0];
    endfunction

    // Apply one item to the behavioral table and return the value it reports.
    function automatic logic [LEVEL_W-1:0] apply_to_levels(input logic [OP_W-1:0]    op,
                                                           input logic [IDX_W-1:0]   org,
                                                           input logic [IDX_W-1:0]   dst,
                                                           input logic [LEVEL_W-1:0] amt);
        logic [LEVEL_W-1:0] result;
        logic [LEVEL_W-1:0] level;
        logic [RATE_W:0]    factor;
        logic [LEVEL_W+RATE_W:0] scaled;
        int active;
        int here;
        int there;
        result = '0;
        active = (node_count_reg > NODES) ? NODES : int'(node_count_reg);
        here   = int'(org) + NODES * int'(dst);
        there  = int'(dst) + NODES * int'(org);
        case (op)
            OP_CLEAR: begin
                for (int k = 0; k < DEPTH; k++) level_table[k] = init_reg;
            end
            OP_ADD: begin
                // Both mirror entries get the amount; a diagonal entry gets it twice.
                level_table[here]  = deposit_level(level_table[here], amt);
                level_table[there] = deposit_level(level_table[there], amt);
            end
            OP_EVAP: begin
                factor = {1'b1, {RATE_W{1'b0}}} - {1'b0, rate_reg};
                for (int y = 0; y < active; y++) begin
                    for (int x = 0; x < active; x++) begin
                        scaled = level_table[x + NODES * y] * factor;
                        level  = scaled[LEVEL_W+FRAC_W-1:FRAC_W];
                        if (level <= floor_reg) level = floor_reg;
                        level_table[x + NODES * y] = level;
                    end
                end
            end
            OP_READ: begin
                result = level_table[here];
            end
            OP_MAX: begin
                for (int y = 0; y < active; y++) begin
                    for (int x = 0; x < active; x++) begin
                        if (level_table[x + NODES * y] > result)
                            result = level_table[x + NODES * y];
                    end
                end
            end
            default: begin
                // Unused codes leave the table alone.
            end
        endcase
        return result;
    endfunction

    // Offer one item after a random gap and record its outcome on acceptance.
    // Valid stays high on return; the next send with a gap or a drain takes it down.
    task automatic send_item(input logic [OP_W-1:0]    op,
                             input logic [IDX_W-1:0]   org,
                             input logic [IDX_W-1:0]   dst,
                             input logic [LEVEL_W-1:0] amt);
        int       gap;
        t_outcome due;
        gap = tx_idle_on ? $urandom_range(0, 5) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_origin      <= org;
        i_destination <= dst;
        i_amount      <= amt;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        due.kind  = op;
        due.value = apply_to_levels(op, org, dst, amt);
        awaited_outcomes.push_back(due);
        op_tally[op]++;
    endtask

    // Stop offering items and wait until every outcome has been seen.
    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (awaited_outcomes.size() != 0) @(posedge i_clk);
    endtask

    // Drain the engine, then write all four registers on consecutive cycles.
    // Bits above the node count and rate widths carry noise.
    task automatic apply_settings(input logic [NCOUNT_W-1:0] nc,
                                  input logic [RATE_W-1:0]   rate,
                                  input logic [LEVEL_W-1:0]  init,
                                  input logic [LEVEL_W-1:0]  flr);
        wait_for_results();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_NODE_COUNT;
        i_cfg_data  <= {(CFG_DATA_W-NCOUNT_W)'($urandom), nc};
        @(negedge i_clk);
        i_cfg_index <= CFG_EVAP_RATE;
        i_cfg_data  <= {(CFG_DATA_W-RATE_W)'($urandom), rate};
        @(negedge i_clk);
        i_cfg_index <= CFG_INIT_LEVEL;
        i_cfg_data  <= init;
        @(negedge i_clk);
        i_cfg_index <= CFG_FLOOR_LEVEL;
        i_cfg_data  <= flr;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        node_count_reg = nc;
        rate_reg       = rate;
        init_reg       = init;
        floor_reg      = flr;
        settings_applied++;
    endtask

    // Receiver: a long hold-off when requested, else a random gap per result.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                i_ready <= 1'b0;
                rx_hold_left--;
            end else if (rx_gap_left > 0) begin
                i_ready <= 1'b0;
                rx_gap_left--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Compare each accepted result with the oldest outcome still awaited.
    always @(posedge i_clk) begin : result_check
        t_outcome due;
        if (i_rst_n && o_valid && i_ready) begin
            results_checked++;
            if (awaited_outcomes.size() == 0) begin
                report_mismatch($sformatf("result with no item pending: value %h kind %0d",
                                          o_value, o_done_kind));
            end else begin
                due = awaited_outcomes.pop_front();
                if (o_value !== due.value)
                    report_mismatch($sformatf("kind %0d value %h, wanted %h",
                                              due.kind, o_value, due.value));
                if (o_done_kind !== due.kind)
                    report_mismatch($sformatf("done_kind %0d, wanted %0d",
                                              o_done_kind, due.kind));
            end
            rx_gap_left = rx_idle_on ? $urandom_range(0, 5) : 0;
        end
    end

    // Convert an integer operation code to the field width.
    function automatic logic [OP_W-1:0] OP_CODE_BITS(input int code);
        return code[OP_W-1:0];
    endfunction

    // Contents after reset with the reset register values, and unused codes.
    task automatic test_reset_state();
        send_item(OP_READ, '0, '0, '0);
        send_item(OP_READ, {IDX_W{1'b1}}, {IDX_W{1'b1}}, LEVEL_TOP);
        // With no active nodes the sweeps see nothing and change nothing.
        send_item(OP_MAX, '0, '0, '0);
        send_item(OP_EVAP, '0, '0, '0);
        send_item(OP_READ, 7'd0, 7'd0, '0);
        send_item(OP_CODE_BITS(FIRST_UNUSED_OP), 7'd3, 7'd4, $urandom);
        send_item(OP_CODE_BITS(LAST_OP_CODE), {IDX_W{1'b1}}, 7'd0, LEVEL_TOP);
    endtask

    // Symmetric deposits, the diagonal double deposit and saturation.
    task automatic test_deposits();
        apply_settings(8'd4, EVAP_RATE_RST, INIT_LEVEL_RST, FLOOR_RST);
        send_item(OP_ADD, 7'd1, 7'd2, 32'h0001_8000);
        send_item(OP_READ, 7'd1, 7'd2, '0);
        send_item(OP_READ, 7'd2, 7'd1, '0);
        send_item(OP_ADD, 7'd3, 7'd3, 32'h0000_0001);
        send_item(OP_READ, 7'd3, 7'd3, '0);
        send_item(OP_ADD, 7'd0, 7'd1, LEVEL_TOP);
        send_item(OP_ADD, 7'd0, 7'd0, '0);
        send_item(OP_MAX, '0, '0, '0);
    endtask

    // Rate of zero, the largest rate, both floor extremes and full-size sweeps.
    task automatic test_evaporation();
        apply_settings(8'd4, '0, INIT_LEVEL_RST, FLOOR_RST);
        send_item(OP_EVAP, '0, '0, '0);
        send_item(OP_READ, 7'd0, 7'd1, '0);
        apply_settings(8'd4, RATE_TOP, INIT_LEVEL_RST, '0);
        send_item(OP_EVAP, '0, '0, '0);
        send_item(OP_READ, 7'd1, 7'd0, '0);
        // A top floor pins every swept entry to the floor.
        apply_settings(8'd128, RATE_W'($urandom), INIT_LEVEL_RST, LEVEL_TOP);
        send_item(OP_EVAP, '0, '0, '0);
        send_item(OP_READ, {IDX_W{1'b1}}, {IDX_W{1'b1}}, '0);
        // A node count above the table size sweeps the full table.
        apply_settings({NCOUNT_W{1'b1}}, RATE_W'($urandom), INIT_LEVEL_RST, LEVEL_TOP);
        send_item(OP_MAX, '0, '0, '0);
    endtask

    // Clear to zero and to the top level, then deposit on a full entry.
    task automatic test_clear_levels();
        apply_settings(8'd3, RATE_W'($urandom), '0, '0);
        send_item(OP_CLEAR, '0, '0, '0);
        send_item(OP_READ, 7'd2, 7'd0, '0);
        send_item(OP_MAX, '0, '0, '0);
        apply_settings(8'd2, RATE_W'($urandom), LEVEL_TOP, FLOOR_RST);
        send_item(OP_CLEAR, '0, '0, '0);
        send_item(OP_ADD, 7'd1, 7'd0, 32'd5);
        send_item(OP_READ, 7'd0, 7'd1, '0);
        send_item(OP_MAX, '0, '0, '0);
    endtask

    // Receiver holds off while the sender keeps offering, then a sender pause.
    task automatic test_output_stall();
        int k;
        apply_settings(8'd6, EVAP_RATE_RST, INIT_LEVEL_RST, FLOOR_RST);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        @(posedge i_clk);
        rx_hold_left = STALL_CYCLES;
        for (k = 0; k < 12; k++) begin
            send_item((k % 3 == 0) ? OP_ADD : OP_READ,
                      IDX_W'($urandom_range(0, 5)), IDX_W'($urandom_range(0, 5)), $urandom);
        end
        wait_for_results();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (k = 0; k < 8; k++) begin
            send_item((k % 2 == 0) ? OP_ADD : OP_READ,
                      IDX_W'($urandom_range(0, 5)), IDX_W'($urandom_range(0, 5)), $urandom);
        end
        wait_for_results();
    endtask

    // Phases of random settings and random items; sweeps stay small mostly.
    task automatic test_random_traffic();
        logic [NCOUNT_W-1:0] nc;
        logic [RATE_W-1:0]   rate;
        logic [LEVEL_W-1:0]  init;
        logic [LEVEL_W-1:0]  flr;
        logic [LEVEL_W-1:0]  amt;
        logic [OP_W-1:0]     op;
        logic [IDX_W-1:0]    org;
        logic [IDX_W-1:0]    dst;
        int phase;
        int k;
        int pick;
        int active;
        int big_sweeps_left;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            pick = $urandom_range(0, 11);
            if (pick == 0)      nc = '0;
            else if (pick == 1) nc = NCOUNT_W'($urandom_range(NODES, (1 << NCOUNT_W) - 1));
            else                nc = NCOUNT_W'($urandom_range(1, 12));
            case ($urandom_range(0, 3))
                0:       rate = '0;
                1:       rate = RATE_TOP;
                default: rate = RATE_W'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       init = LEVEL_TOP;
                1:       init = $urandom;
                default: init = $urandom_range(0, 32'h00FF_FFFF);
            endcase
            case ($urandom_range(0, 3))
                0:       flr = '0;
                1:       flr = $urandom;
                default: flr = $urandom_range(0, 32'h0001_0000);
            endcase
            apply_settings(nc, rate, init, flr);
            active = (nc > NODES) ? NODES : int'(nc);
            big_sweeps_left = 1;
            // Vary idling per phase so some stretches run back to back.
            tx_idle_on = (phase % 3) != 1;
            rx_idle_on = (phase % 3) != 2;
            if ($urandom_range(0, 2) == 0) send_item(OP_CLEAR, '0, '0, '0);
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 38)      op = OP_ADD;
                else if (pick < 70) op = OP_READ;
                else if (pick < 80) op = OP_EVAP;
                else if (pick < 92) op = OP_MAX;
                else                op = OP_CODE_BITS($urandom_range(FIRST_UNUSED_OP,
                                                                     LAST_OP_CODE));
                // Sweeps over more than SMALL_NODE_LIMIT nodes are slow, so allow only one per phase.
                if ((op == OP_EVAP || op == OP_MAX) && active > SMALL_NODE_LIMIT) begin
                    if (big_sweeps_left == 0) op = OP_READ;
                    else                      big_sweeps_left--;
                end
                if (active > 0 && $urandom_range(0, 4) != 0) begin
                    org = IDX_W'($urandom_range(0, active - 1));
                    dst = IDX_W'($urandom_range(0, active - 1));
                end else begin
                    org = IDX_W'($urandom);
                    dst = IDX_W'($urandom);
                end
                case ($urandom_range(0, 2))
                    0:       amt = $urandom_range(0, 32'h0002_0000);
                    1:       amt = LEVEL_TOP - $urandom_range(0, 32'h0FFF_FFFF);
                    default: amt = $urandom;
                endcase
                send_item(op, org, dst, amt);
            end
        end
    endtask

    // Reset, then run every test in turn and report.
    initial begin
        int unused_ops;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_NODE_COUNT;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_operation   = OP_CLEAR;
        i_origin      = '0;
        i_destination = '0;
        i_amount      = '0;
        foreach (op_tally[k]) op_tally[k] = 0;
        node_count_reg = NODE_COUNT_RST;
        rate_reg       = EVAP_RATE_RST;
        init_reg       = INIT_LEVEL_RST;
        floor_reg      = FLOOR_RST;
        for (int k = 0; k < DEPTH; k++) level_table[k] = INIT_LEVEL_RST;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_deposits();
        test_evaporation();
        test_clear_levels();
        test_output_stall();
        test_random_traffic();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        unused_ops = 0;
        for (int k = FIRST_UNUSED_OP; k <= LAST_OP_CODE; k++) unused_ops += op_tally[k];
        $display("Sent %0d clear, %0d add, %0d evaporate, %0d read, %0d max, %0d %s",
                 op_tally[OP_CLEAR], op_tally[OP_ADD], op_tally[OP_EVAP],
                 op_tally[OP_READ], op_tally[OP_MAX], unused_ops, "unused-code items");
        $display("Checked %0d results over %0d register settings, %0d mismatches",
                 results_checked, settings_applied, mismatch_count);
        if (mismatch_count == 0) begin
            $display("** pheromone_table_engine: PASSED **");
        end else begin
            $display("** pheromone_table_engine: FAILED **");
        end
        $finish;
    end

endmodule

>>> pheromone_table_engine.f
rtl/core/pte_pkg.sv
rtl/core/pte_ram.sv
rtl/core/pheromone_table_engine.sv
sim/tb_pheromone_table_engine.sv
